// ===== rtl/core/lpsd_pkg.sv =====
// Package for the length-prefixed string deframer: sizes, character codes,
// result kinds and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lpsd_pkg;

	// Table size and length field width
	localparam int MAX_STRINGS = 16;
	localparam int LENGTH_BITS = 16;

	// Count/index widths
	localparam int CNT_W = $clog2(MAX_STRINGS + 1);
	localparam int IDX_W = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
	// Accumulator holds either a count or a length
	localparam int ACC_W = (LENGTH_BITS > CNT_W) ? LENGTH_BITS : CNT_W;
	// Room for acc * 10 + 9
	localparam int NXT_W = ACC_W + 4;

	// Fixed result field widths
	localparam int BYTE_W  = 8;
	localparam int OUT_IDX_W = 4;

	localparam logic [NXT_W-1:0] LEN_MAX   = NXT_W'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [NXT_W-1:0] COUNT_MAX = NXT_W'(MAX_STRINGS);

	// Header characters
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_BAR   = 8'h7C;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// What the output register is loaded with
	typedef enum logic [1:0] {
		RES_BYTE,
		RES_MARKER,
		RES_EMPTY_MSG,
		RES_ERROR
	} result_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic         new_msg;      // clear all message state (highest priority)
		logic         acc_shift;    // accumulate a decimal digit
		logic         count_load;   // take the accumulator as string count
		logic         store_length; // write the accumulator into the table
		logic         cur_inc;      // step to the next string
		logic         rem_load;     // load remaining bytes of current string
		logic         rem_dec;      // one payload byte consumed
		logic         out_load;     // load the output register
		result_kind_t kind;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_digit;
		logic is_colon;
		logic is_comma;
		logic is_bar;
		logic count_ovf;       // next count above table size
		logic len_ovf;         // next length above field range
		logic digit_seen;
		logic stored_ge_count;
		logic stored_eq_count;
		logic count_zero;
		logic cur_ge_count;
		logic cur_len_zero;    // table entry of current string is zero
		logic rem_last;        // this payload byte ends the string
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpsd_if.sv =====
// Stream interfaces of the deframer: encoded byte input and decoded results.
// Depends on lpsd_pkg.
`default_nettype none

interface lpsd_in_if;
	logic                      valid;
	logic                      ready;
	logic [lpsd_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpsd_out_if;
	logic                         valid;
	logic                         ready;
	logic [lpsd_pkg::BYTE_W-1:0]    payload_byte;
	logic [lpsd_pkg::OUT_IDX_W-1:0] string_index;
	logic                         has_byte;
	logic                         string_end;
	logic                         message_end;
	logic                         format_error;

	modport source (output valid, output payload_byte, output string_index,
		output has_byte, output string_end, output message_end,
		output format_error, input ready);
	modport sink   (input valid, input payload_byte, input string_index,
		input has_byte, input string_end, input message_end,
		input format_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpsd_datapath.sv =====
// Deframer datapath: digit accumulator, length table, string and byte
// counters, output result register. Depends on lpsd_pkg.
`default_nettype none

module lpsd_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [lpsd_pkg::BYTE_W-1:0]    data_byte,
	input  wire lpsd_pkg::cmd_t                 cmd,
	output lpsd_pkg::status_t                   status,
	output logic [lpsd_pkg::BYTE_W-1:0]         payload_byte,
	output logic [lpsd_pkg::OUT_IDX_W-1:0]      string_index,
	output logic                                has_byte,
	output logic                                string_end,
	output logic                                message_end,
	output logic                                format_error
);
	import lpsd_pkg::*;

	logic [ACC_W-1:0]       acc_q;
	logic                   digit_seen_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       stored_q;
	logic [CNT_W-1:0]       cur_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] length_tbl_q [MAX_STRINGS];

	logic [NXT_W-1:0]       acc_x;
	logic [NXT_W-1:0]       acc_nxt;
	logic [LENGTH_BITS-1:0] cur_len;
	logic [CNT_W:0]         cur_plus1;
	logic                   cur_last;
	logic [CNT_W+3:0]       cur_ext;
	logic [OUT_IDX_W-1:0]   cur_idx;

	// Decimal accumulate: acc * 10 + digit (low nibble of an ASCII digit)
	always_comb begin
		acc_x   = NXT_W'(acc_q);
		acc_nxt = (acc_x << 3) + (acc_x << 1) + NXT_W'(data_byte[3:0]);
	end

	assign cur_len   = length_tbl_q[cur_q[IDX_W-1:0]];
	assign cur_plus1 = {1'b0, cur_q} + (CNT_W+1)'(1);
	assign cur_last  = cur_plus1 >= {1'b0, count_q};
	assign cur_ext   = {4'b0, cur_q};
	assign cur_idx   = cur_ext[OUT_IDX_W-1:0];

	// Status towards the controller
	always_comb begin
		status.is_digit        = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		status.is_colon        = data_byte == CH_COLON;
		status.is_comma        = data_byte == CH_COMMA;
		status.is_bar          = data_byte == CH_BAR;
		status.count_ovf       = acc_nxt > COUNT_MAX;
		status.len_ovf         = acc_nxt > LEN_MAX;
		status.digit_seen      = digit_seen_q;
		status.stored_ge_count = stored_q >= count_q;
		status.stored_eq_count = stored_q == count_q;
		status.count_zero      = count_q == '0;
		status.cur_ge_count    = cur_q >= count_q;
		status.cur_len_zero    = cur_len == '0;
		status.rem_last        = rem_q <= LENGTH_BITS'(1);
	end

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			digit_seen_q <= 1'b0;
			count_q      <= '0;
			stored_q     <= '0;
			cur_q        <= '0;
			rem_q        <= '0;
		end else if (cmd.new_msg) begin
			acc_q        <= '0;
			digit_seen_q <= 1'b0;
			count_q      <= '0;
			stored_q     <= '0;
			cur_q        <= '0;
			rem_q        <= '0;
		end else begin
			if (cmd.acc_shift) begin
				acc_q        <= acc_nxt[ACC_W-1:0];
				digit_seen_q <= 1'b1;
			end
			if (cmd.count_load) begin
				count_q      <= acc_q[CNT_W-1:0];
				stored_q     <= '0;
				acc_q        <= '0;
				digit_seen_q <= 1'b0;
			end
			if (cmd.store_length) begin
				stored_q     <= stored_q + CNT_W'(1);
				acc_q        <= '0;
				digit_seen_q <= 1'b0;
			end
			if (cmd.cur_inc)
				cur_q <= cur_q + CNT_W'(1);
			if (cmd.rem_load)
				rem_q <= cur_len;
			else if (cmd.rem_dec && rem_q != '0)
				rem_q <= rem_q - LENGTH_BITS'(1);
		end
	end

	// Length table: entries are only read once written in the same header
	always_ff @(posedge clk) begin
		if (cmd.store_length && !cmd.new_msg)
			length_tbl_q[stored_q[IDX_W-1:0]] <= acc_q[LENGTH_BITS-1:0];
	end

	// Output result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.kind)
				RES_BYTE: begin
					payload_byte <= data_byte;
					string_index <= cur_idx;
					has_byte     <= 1'b1;
					string_end   <= status.rem_last;
					message_end  <= status.rem_last && cur_last;
					format_error <= 1'b0;
				end
				RES_MARKER: begin
					payload_byte <= '0;
					string_index <= cur_idx;
					has_byte     <= 1'b0;
					string_end   <= 1'b1;
					message_end  <= cur_last;
					format_error <= 1'b0;
				end
				RES_EMPTY_MSG: begin
					payload_byte <= '0;
					string_index <= '0;
					has_byte     <= 1'b0;
					string_end   <= 1'b0;
					message_end  <= 1'b1;
					format_error <= 1'b0;
				end
				RES_ERROR: begin
					payload_byte <= '0;
					string_index <= '0;
					has_byte     <= 1'b0;
					string_end   <= 1'b0;
					message_end  <= 1'b0;
					format_error <= 1'b1;
				end
				default: begin
					payload_byte <= '0;
					string_index <= '0;
					has_byte     <= 1'b0;
					string_end   <= 1'b0;
					message_end  <= 1'b0;
					format_error <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lpsd_controller.sv =====
// Deframer controller: phase state machine, input/output handshakes and
// commands to the datapath. Depends on lpsd_pkg.
`default_nettype none

module lpsd_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lpsd_pkg::status_t status,
	output lpsd_pkg::cmd_t         cmd
);
	import lpsd_pkg::*;

	typedef enum logic [1:0] {
		ST_COUNT,
		ST_LENGTHS,
		ST_PAYLOAD,
		ST_ADVANCE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	// Output slot frees up when empty or being taken this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q != ST_ADVANCE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode of the current byte or advance step
	always_comb begin
		cmd     = '0;
		cmd.kind = RES_BYTE;
		state_d = state_q;

		unique case (state_q)
			ST_COUNT: begin
				if (accept) begin
					if (status.is_digit && !status.count_ovf) begin
						cmd.acc_shift = 1'b1;
					end else if (status.is_colon && status.digit_seen) begin
						cmd.count_load = 1'b1;
						state_d = ST_LENGTHS;
					end else begin
						cmd.out_load = 1'b1;
						cmd.kind     = RES_ERROR;
						cmd.new_msg  = 1'b1;
						state_d = ST_COUNT;
					end
				end
			end
			ST_LENGTHS: begin
				if (accept) begin
					priority if (status.is_digit && !status.len_ovf) begin
						cmd.acc_shift = 1'b1;
					end else if (status.is_comma && status.digit_seen
							&& !status.stored_ge_count) begin
						cmd.store_length = 1'b1;
					end else if (status.is_bar && !status.digit_seen
							&& status.stored_eq_count) begin
						if (status.count_zero) begin
							cmd.out_load = 1'b1;
							cmd.kind     = RES_EMPTY_MSG;
							cmd.new_msg  = 1'b1;
							state_d = ST_COUNT;
						end else begin
							state_d = ST_ADVANCE;
						end
					end else begin
						cmd.out_load = 1'b1;
						cmd.kind     = RES_ERROR;
						cmd.new_msg  = 1'b1;
						state_d = ST_COUNT;
					end
				end
			end
			ST_PAYLOAD: begin
				if (accept) begin
					cmd.out_load = 1'b1;
					cmd.kind     = RES_BYTE;
					cmd.rem_dec  = 1'b1;
					if (status.rem_last) begin
						cmd.cur_inc = 1'b1;
						state_d = ST_ADVANCE;
					end
				end
			end
			ST_ADVANCE: begin
				// One empty-string marker per cycle while the output slot is free, then arm or finish
				if (slot_free) begin
					if (status.cur_ge_count) begin
						cmd.new_msg = 1'b1;
						state_d = ST_COUNT;
					end else if (status.cur_len_zero) begin
						cmd.out_load = 1'b1;
						cmd.kind     = RES_MARKER;
						cmd.cur_inc  = 1'b1;
					end else begin
						cmd.rem_load = 1'b1;
						state_d = ST_PAYLOAD;
					end
				end
			end
			default: begin
				state_d = ST_COUNT;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COUNT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_string_deframer_top.sv =====
// Top level of the length-prefixed string deframer: joins controller and
// datapath to the byte and result streams. Depends on lpsd_pkg, lpsd_if,
// lpsd_controller and lpsd_datapath.
//
// Takes an encoded message a byte per transaction: decimal count, ':', one
// decimal length per string each ended by ',', '|', then the payload. A
// payload byte gives one result with its string index and end marks.
// After '|' and after the last byte of each string the controller gives
// a marker result for each following empty string, then fetches the next
// length or closes the message, and takes no byte meanwhile. A malformed
// header gives one result with format_error set and the next byte starts a
// new count; '|' with a count of zero gives a single message_end result.
// Results pass through a single output register, so a byte is taken while
// the previous result is being handed over.
`default_nettype none

module length_prefixed_string_deframer_top (
	input wire logic    clk,
	input wire logic    arst_n,
	lpsd_in_if.sink     byte_stream,
	lpsd_out_if.source  results
);
	import lpsd_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Phase sequencing and handshakes
	lpsd_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_stream.valid),
		.in_ready  (byte_stream.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Accumulator, table, counters, result register
	lpsd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (byte_stream.data_byte),
		.cmd          (cmd),
		.status       (status),
		.payload_byte (results.payload_byte),
		.string_index (results.string_index),
		.has_byte     (results.has_byte),
		.string_end   (results.string_end),
		.message_end  (results.message_end),
		.format_error (results.format_error)
	);

endmodule

`default_nettype wire
